// File: src/btlv_pkg.sv
// shared types and codes of the ber-tlv stream parser
`timescale 1ns / 1ps
`default_nettype none
package btlv_pkg;

  // stack entry and position widths
  localparam int OFS_W = 16;
  localparam int POS_W = OFS_W + 1;

  // result event codes
  localparam logic [1:0] EV_HDR_BYTE = 2'd0;
  localparam logic [1:0] EV_HDR_DONE = 2'd1;
  localparam logic [1:0] EV_VALUE    = 2'd2;
  localparam logic [1:0] EV_ERROR    = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNC     = 3'd1;
  localparam logic [2:0] ERR_OVERRUN   = 3'd2;
  localparam logic [2:0] ERR_TAG_LONG  = 3'd3;
  localparam logic [2:0] ERR_LEN_LONG  = 3'd4;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd5;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] tag_value;
    logic [15:0] value_length;
    logic [1:0]  object_class;
    logic        is_constructed;
    logic [3:0]  nesting_depth;
    logic        tag_match;
    logic [7:0]  value_out;
    logic [3:0]  levels_closed;
    logic [2:0]  error_code;
  } out_beat_t;

  // per-cell control from the parser
  typedef struct packed {
    logic push;
    logic in_use;
    logic is_top;
  } stack_ctl_t;

endpackage
`default_nettype wire

// File: src/btlv_stack_cell.sv
// one level of the end-offset stack with its pop chain link
`timescale 1ns / 1ps
`default_nettype none
module btlv_stack_cell (
  input  wire logic                      clk,
  input  wire btlv_pkg::stack_ctl_t      ctl,
  input  wire logic [btlv_pkg::OFS_W-1:0] push_ofs,
  input  wire logic [btlv_pkg::POS_W-1:0] pos_after,
  input  wire logic                      pop_in,
  output logic [btlv_pkg::OFS_W-1:0]     ofs,
  output logic                           pop_out
);

  logic [btlv_pkg::OFS_W-1:0] ofs_r;

  // end offset of the object open at this level
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ofs_r <= push_ofs;
    end
  end

  assign ofs = ofs_r;

  // this level closes when it ends here and everything above it closes too
  assign pop_out = ctl.in_use && ({1'b0, ofs_r} == pos_after) && (ctl.is_top || pop_in);

endmodule
`default_nettype wire

// File: src/ber_tlv_stream_parser_core.sv
// ber-tlv stream parser top level: header decoder, nesting stack cells, result register
//
// Bytes of an encoded buffer enter on the in_ channel (valid/ready), one per beat,
// with last_byte marking the final byte of the buffer. Every input beat gives
// exactly one result beat on the out_ channel: header byte, header complete
// (tag, length, class, constructed, search match), primitive value byte or error.
// The search tag is written on the cfg_ channel, which is always ready; write it
// only while no byte is in flight.
// The result of a byte is registered: it enters the output register at the
// clock edge that accepts the byte. Throughput is one byte per cycle while
// the receiver takes results; the header decode, the top end-offset compare
// and the pop chain through the stack cells all settle in the cycle that accepts the byte.
// When the receiver stalls, the output register holds its result and one
// further byte is taken only as the register drains (in_ready follows out_ready).
// Reset clears the parser state and the search tag; the stack contents are
// only read at levels that were pushed. After the last_byte beat the parser
// returns to its reset state, keeping the search tag.
`timescale 1ns / 1ps
`default_nettype none
module ber_tlv_stream_parser_core #(
  parameter int MAX_DEPTH    = 8,
  parameter int TAG_BYTES    = 4,
  parameter int LENGTH_BYTES = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire btlv_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output btlv_pkg::out_beat_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [31:0]         cfg_data
);

  localparam int SLW = $clog2(MAX_DEPTH + 1);
  localparam int TCW = $clog2(TAG_BYTES + 1);
  localparam int LCW = $clog2(LENGTH_BYTES + 1);
  localparam int OW  = btlv_pkg::OFS_W;
  localparam int PW  = btlv_pkg::POS_W;

  // parse phases
  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_TAG   = 3'd1;
  localparam logic [2:0] PH_LEN1  = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_VALUE = 3'd4;
  localparam logic [2:0] PH_WAIT  = 3'd5;

  logic [2:0]     phase_r, phase_nxt;
  logic [31:0]    tag_r, tag_nxt;
  logic [TCW-1:0] tag_cnt_r, tag_cnt_nxt;
  logic [2:0]     flags_r, flags_nxt;
  logic [15:0]    len_r, len_nxt;
  logic [LCW-1:0] len_left_r, len_left_nxt;
  logic [15:0]    pos_r, pos_nxt;
  logic [SLW-1:0] level_r, level_nxt;
  logic           match_seen_r, match_seen_nxt;
  logic           err_r, err_nxt;
  logic [31:0]    search_tag_r;
  logic           out_valid_r;
  btlv_pkg::out_beat_t out_data_r;

  logic                  in_fire;
  logic [7:0]            b;
  logic [15:0]           pos_base;
  logic [PW-1:0]         pos_after;
  logic [PW:0]           end_sum;
  logic [OW-1:0]         top_ofs;
  logic [MAX_DEPTH-1:0]  pop_vec;
  logic [MAX_DEPTH-1:0]  top_vec;
  logic [OW-1:0]         cell_ofs [MAX_DEPTH];
  logic [SLW-1:0]        pop_cnt;
  logic [5:0]            closed_sum;
  logic                  do_push;
  logic                  do_pop;
  logic                  err_now;
  logic                  complete;
  btlv_pkg::out_beat_t   res;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.data_byte;

  // position of the byte after this one within the top-level object
  assign pos_base  = (phase_r == PH_FIRST && level_r == '0) ? 16'd0 : pos_r;
  assign pos_after = {1'b0, pos_base} + PW'(1);

  // stack cells, level 0 at the bottom; the pop chain runs downward from the top
  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    btlv_pkg::stack_ctl_t ctl;
    logic                 pop_in;

    assign ctl.push   = in_fire && do_push && (level_r == SLW'(i));
    assign ctl.in_use = level_r > SLW'(i);
    assign ctl.is_top = level_r == SLW'(i + 1);
    assign top_vec[i] = ctl.is_top;

    if (i == MAX_DEPTH - 1) begin : g_last
      assign pop_in = 1'b0;
    end else begin : g_mid
      assign pop_in = pop_vec[i + 1];
    end

    btlv_stack_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .push_ofs  (end_sum[OW-1:0]),
      .pos_after (pos_after),
      .pop_in    (pop_in),
      .ofs       (cell_ofs[i]),
      .pop_out   (pop_vec[i])
    );
  end

  // top end offset and number of levels that end here
  always_comb begin
    top_ofs = '0;
    pop_cnt = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      top_ofs = top_ofs | (top_vec[i] ? cell_ofs[i] : '0);
      pop_cnt = pop_cnt + SLW'(pop_vec[i]);
    end
  end

  assign closed_sum = 6'(pop_cnt) + 6'd1;

  // header decode and result
  always_comb begin
    phase_nxt      = phase_r;
    tag_nxt        = tag_r;
    tag_cnt_nxt    = tag_cnt_r;
    flags_nxt      = flags_r;
    len_nxt        = len_r;
    len_left_nxt   = len_left_r;
    pos_nxt        = pos_r;
    level_nxt      = level_r;
    match_seen_nxt = match_seen_r;
    err_nxt        = err_r;
    err_now        = 1'b0;
    complete       = 1'b0;
    do_push        = 1'b0;
    do_pop         = 1'b0;
    end_sum        = '0;

    res                = '0;
    res.event_res      = btlv_pkg::EV_HDR_BYTE;
    res.error_code     = btlv_pkg::ERR_NONE;
    res.value_out      = b;

    if (err_r) begin
      res.event_res = btlv_pkg::EV_ERROR;
    end else begin
      pos_nxt = pos_after[PW-1] ? 16'hFFFF : pos_after[15:0];

      unique case (phase_r)
        PH_FIRST: begin
          flags_nxt   = {b[7:6], b[5]};
          tag_nxt     = {24'd0, b};
          tag_cnt_nxt = TCW'(1);
          phase_nxt   = (b[4:0] == 5'h1F) ? PH_TAG : PH_LEN1;
        end
        PH_TAG: begin
          if (tag_cnt_r >= TCW'(TAG_BYTES)) begin
            err_now        = 1'b1;
            res.error_code = btlv_pkg::ERR_TAG_LONG;
          end else begin
            tag_nxt     = {tag_r[23:0], b};
            tag_cnt_nxt = tag_cnt_r + TCW'(1);
            if (!b[7]) begin
              phase_nxt = PH_LEN1;
            end
          end
        end
        PH_LEN1: begin
          if (!b[7]) begin
            len_nxt  = {8'd0, b};
            complete = 1'b1;
          end else if (b[6:0] == 7'd0) begin
            len_nxt  = 16'd0;
            complete = 1'b1;
          end else if (b[6:0] > 7'(LENGTH_BYTES)) begin
            err_now        = 1'b1;
            res.error_code = btlv_pkg::ERR_LEN_LONG;
          end else begin
            len_nxt      = 16'd0;
            len_left_nxt = LCW'(b[6:0]);
            phase_nxt    = PH_LEN;
          end
        end
        PH_LEN: begin
          if (len_r[15:8] != 8'd0) begin
            err_now        = 1'b1;
            res.error_code = btlv_pkg::ERR_LEN_LONG;
          end else begin
            len_nxt      = {len_r[7:0], b};
            len_left_nxt = len_left_r - LCW'(1);
            if (len_left_r == LCW'(1)) begin
              complete = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          res.event_res = btlv_pkg::EV_VALUE;
          len_nxt       = (len_r != 16'd0) ? len_r - 16'd1 : 16'd0;
          if (len_nxt == 16'd0) begin
            phase_nxt = PH_FIRST;
            do_pop    = 1'b1;
          end
        end
        default: begin
          err_now        = 1'b1;
          res.error_code = btlv_pkg::ERR_NONE;
        end
      endcase

      // header running into the end of its parent
      if (!err_now && res.event_res == btlv_pkg::EV_HDR_BYTE && !complete &&
          level_r != '0 && pos_after >= {1'b0, top_ofs}) begin
        err_now        = 1'b1;
        res.error_code = btlv_pkg::ERR_OVERRUN;
      end

      // completed header: bounds, depth, then enter, stream or close
      if (!err_now && complete) begin
        end_sum = {1'b0, pos_after} + {2'b00, len_nxt};
        if (level_r != '0 && end_sum > {2'b00, top_ofs}) begin
          err_now        = 1'b1;
          res.error_code = btlv_pkg::ERR_OVERRUN;
        end else if (end_sum[PW:OW] != '0) begin
          err_now        = 1'b1;
          res.error_code = btlv_pkg::ERR_LEN_LONG;
        end else if (flags_nxt[0] && len_nxt != 16'd0 &&
                     level_r >= SLW'(MAX_DEPTH)) begin
          err_now        = 1'b1;
          res.error_code = btlv_pkg::ERR_TOO_DEEP;
        end else begin
          res.event_res    = btlv_pkg::EV_HDR_DONE;
          res.tag_value    = tag_nxt;
          res.value_length = len_nxt;
          if (!match_seen_r && tag_nxt == search_tag_r) begin
            res.tag_match  = 1'b1;
            match_seen_nxt = 1'b1;
          end
          if (len_nxt == 16'd0) begin
            phase_nxt = PH_FIRST;
            do_pop    = 1'b1;
          end else if (flags_nxt[0]) begin
            do_push   = 1'b1;
            phase_nxt = PH_FIRST;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end
      end

      // class and constructed bits on header results
      if (!err_now && (res.event_res == btlv_pkg::EV_HDR_BYTE ||
                       res.event_res == btlv_pkg::EV_HDR_DONE)) begin
        res.object_class   = flags_nxt[2:1];
        res.is_constructed = flags_nxt[0];
      end

      // stack level and closed count
      res.nesting_depth = 4'(level_r);
      if (do_push) begin
        level_nxt = level_r + SLW'(1);
      end else if (do_pop) begin
        level_nxt           = level_r - pop_cnt;
        res.levels_closed   = (closed_sum > 6'd15) ? 4'hF : closed_sum[3:0];
      end

      // fresh error: blank the result and wait for the last byte
      if (err_now) begin
        res.event_res      = btlv_pkg::EV_ERROR;
        res.tag_value      = '0;
        res.value_length   = '0;
        res.object_class   = '0;
        res.is_constructed = 1'b0;
        res.tag_match      = 1'b0;
        res.levels_closed  = '0;
        match_seen_nxt     = match_seen_r;
        level_nxt          = level_r;
        err_nxt            = 1'b1;
        phase_nxt          = PH_WAIT;
      end
    end

    if (res.event_res == btlv_pkg::EV_ERROR) begin
      res.nesting_depth = 4'(level_r);
    end

    // buffer ends with something still open
    if (in_data.last_byte && !err_now && !err_r &&
        !(phase_nxt == PH_FIRST && level_nxt == '0)) begin
      res.event_res      = btlv_pkg::EV_ERROR;
      res.error_code     = btlv_pkg::ERR_TRUNC;
      res.tag_value      = '0;
      res.value_length   = '0;
      res.object_class   = '0;
      res.is_constructed = 1'b0;
      res.tag_match      = 1'b0;
      res.levels_closed  = '0;
      res.nesting_depth  = 4'(level_nxt);
    end

    // back to reset state after the last byte
    if (in_data.last_byte) begin
      phase_nxt      = PH_FIRST;
      tag_nxt        = '0;
      tag_cnt_nxt    = '0;
      flags_nxt      = '0;
      len_nxt        = '0;
      len_left_nxt   = '0;
      pos_nxt        = '0;
      level_nxt      = '0;
      match_seen_nxt = 1'b0;
      err_nxt        = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST;
      tag_r        <= '0;
      tag_cnt_r    <= '0;
      flags_r      <= '0;
      len_r        <= '0;
      len_left_r   <= '0;
      pos_r        <= '0;
      level_r      <= '0;
      match_seen_r <= 1'b0;
      err_r        <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      tag_r        <= tag_nxt;
      tag_cnt_r    <= tag_cnt_nxt;
      flags_r      <= flags_nxt;
      len_r        <= len_nxt;
      len_left_r   <= len_left_nxt;
      pos_r        <= pos_nxt;
      level_r      <= level_nxt;
      match_seen_r <= match_seen_nxt;
      err_r        <= err_nxt;
    end
  end

  // search tag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_tag_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      search_tag_r <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  // stack never goes past its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= SLW'(MAX_DEPTH))
    else $error("stack level beyond depth");

  // a latched error keeps the parser waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> phase_r == PH_WAIT)
    else $error("error latched outside wait phase");

  // the last byte returns the parser to its reset state
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=>
      phase_r == PH_FIRST && level_r == '0 && !err_r && !match_seen_r)
    else $error("state not cleared after last byte");

  // every accepted beat leaves a result in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat gave no result");

endmodule
`default_nettype wire

// File: verif/btlv_parse_checker.sv
`timescale 1ns / 1ps
// result checker for the ber-tlv stream parser: predicts every result beat and compares it
module btlv_parse_checker #(
  parameter int MAX_DEPTH    = 8,
  parameter int TAG_BYTES    = 4,
  parameter int LENGTH_BYTES = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  btlv_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  btlv_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  events_due
);

  // header decoder states of the predicted parser
  localparam logic [2:0] ST_TAG_FIRST = 3'd0;
  localparam logic [2:0] ST_TAG_MORE  = 3'd1;
  localparam logic [2:0] ST_LEN_FIRST = 3'd2;
  localparam logic [2:0] ST_LEN_MORE  = 3'd3;
  localparam logic [2:0] ST_VALUE     = 3'd4;
  localparam logic [2:0] ST_DRAIN     = 3'd5;

  // predicted parser state and search register
  logic [2:0]   state;
  logic [31:0]  tag_acc;
  int           tag_cnt;
  logic [1:0]   hdr_class;
  logic         hdr_cons;
  int           len_acc;
  int           len_left;
  int           pos;
  int           end_ofs [MAX_DEPTH];
  int           lvl;
  bit           match_done;
  bit           err_hold;
  logic [31:0]  search_tag;

  // result beats still owed by the block, oldest first
  btlv_pkg::out_beat_t tlv_event_q [$];
  int                  beat_no;

  // back to the state after a last byte (search tag kept)
  function void clear_parser();
    state      = ST_TAG_FIRST;
    tag_acc    = '0;
    tag_cnt    = 0;
    hdr_class  = '0;
    hdr_cons   = 1'b0;
    len_acc    = 0;
    len_left   = 0;
    pos        = 0;
    lvl        = 0;
    match_done = 1'b0;
    err_hold   = 1'b0;
    foreach (end_ofs[i]) end_ofs[i] = 0;
  endfunction

  // close the current object and pop every enclosing one that ends here
  function int close_levels(input int pos_after);
    int closed;
    closed = 1;
    while (lvl > 0 && lvl <= MAX_DEPTH && end_ofs[lvl-1] == pos_after) begin
      lvl--;
      closed++;
    end
    return (closed > 15) ? 15 : closed;
  endfunction

  // expected result of one accepted byte, advancing the predicted state
  function btlv_pkg::out_beat_t parse_byte(input logic [7:0] b, input logic fin);
    btlv_pkg::out_beat_t r;
    bit         fail_now;
    bit         done;
    bit         latched_in;
    int         pos_after;
    int         obj_end;
    logic [2:0] code;
    r          = '0;
    r.value_out = b;
    fail_now   = 1'b0;
    done       = 1'b0;
    code       = btlv_pkg::ERR_NONE;
    latched_in = err_hold;
    if (latched_in) begin
      r.event_res = btlv_pkg::EV_ERROR;
    end else begin
      // offset restarts with each top-level object
      if (state == ST_TAG_FIRST && lvl == 0) pos = 0;
      pos_after = pos + 1;
      pos = (pos_after > 'hFFFF) ? 'hFFFF : pos_after;
      r.nesting_depth = 4'(lvl);
      r.event_res = btlv_pkg::EV_HDR_BYTE;
      unique case (state)
        ST_TAG_FIRST: begin
          hdr_class = b[7:6];
          hdr_cons  = b[5];
          tag_acc   = {24'h0, b};
          tag_cnt   = 1;
          state     = (b[4:0] == 5'h1F) ? ST_TAG_MORE : ST_LEN_FIRST;
        end
        ST_TAG_MORE: begin
          if (tag_cnt >= TAG_BYTES) begin
            fail_now = 1'b1;
            code     = btlv_pkg::ERR_TAG_LONG;
          end else begin
            tag_acc = {tag_acc[23:0], b};
            tag_cnt++;
            if (!b[7]) state = ST_LEN_FIRST;
          end
        end
        ST_LEN_FIRST: begin
          if (!b[7]) begin
            len_acc = int'(b);
            done    = 1'b1;
          end else if (b[6:0] == 7'd0) begin
            len_acc = 0;
            done    = 1'b1;
          end else if (int'(b[6:0]) > LENGTH_BYTES) begin
            fail_now = 1'b1;
            code     = btlv_pkg::ERR_LEN_LONG;
          end else begin
            len_acc  = 0;
            len_left = int'(b[6:0]);
            state    = ST_LEN_MORE;
          end
        end
        ST_LEN_MORE: begin
          if ((len_acc >> 8) != 0) begin
            fail_now = 1'b1;
            code     = btlv_pkg::ERR_LEN_LONG;
          end else begin
            len_acc = ((len_acc << 8) | int'(b)) & 'hFFFF;
            len_left--;
            if (len_left == 0) done = 1'b1;
          end
        end
        ST_VALUE: begin
          r.event_res = btlv_pkg::EV_VALUE;
          if (len_acc > 0) len_acc--;
          if (len_acc == 0) begin
            state = ST_TAG_FIRST;
            r.levels_closed = 4'(close_levels(pos_after));
          end
        end
        default: begin
          fail_now = 1'b1;
          code     = btlv_pkg::ERR_NONE;
        end
      endcase

      // header still open when the parent runs out
      if (!fail_now && r.event_res == btlv_pkg::EV_HDR_BYTE && !done && lvl > 0 &&
          pos_after >= end_ofs[lvl-1]) begin
        fail_now = 1'b1;
        code     = btlv_pkg::ERR_OVERRUN;
      end

      // completed header: bounds, depth, then enter, stream or close
      if (!fail_now && done) begin
        obj_end = pos_after + len_acc;
        if (lvl > 0 && obj_end > end_ofs[lvl-1]) begin
          fail_now = 1'b1;
          code     = btlv_pkg::ERR_OVERRUN;
        end else if (obj_end > 'hFFFF) begin
          fail_now = 1'b1;
          code     = btlv_pkg::ERR_LEN_LONG;
        end else if (hdr_cons && len_acc != 0 && lvl >= MAX_DEPTH) begin
          fail_now = 1'b1;
          code     = btlv_pkg::ERR_TOO_DEEP;
        end else begin
          r.event_res    = btlv_pkg::EV_HDR_DONE;
          r.tag_value    = tag_acc;
          r.value_length = 16'(len_acc);
          if (!match_done && tag_acc == search_tag) begin
            r.tag_match = 1'b1;
            match_done  = 1'b1;
          end
          if (len_acc == 0) begin
            state = ST_TAG_FIRST;
            r.levels_closed = 4'(close_levels(pos_after));
          end else if (hdr_cons) begin
            end_ofs[lvl] = obj_end;
            lvl++;
            state = ST_TAG_FIRST;
          end else begin
            state = ST_VALUE;
          end
        end
      end

      if (!fail_now && (r.event_res == btlv_pkg::EV_HDR_BYTE ||
                        r.event_res == btlv_pkg::EV_HDR_DONE)) begin
        r.object_class   = hdr_class;
        r.is_constructed = hdr_cons;
      end
      if (fail_now) begin
        r.event_res      = btlv_pkg::EV_ERROR;
        r.tag_value      = '0;
        r.value_length   = '0;
        r.object_class   = '0;
        r.is_constructed = 1'b0;
        r.tag_match      = 1'b0;
        r.levels_closed  = '0;
        err_hold         = 1'b1;
        state            = ST_DRAIN;
      end
    end

    if (r.event_res == btlv_pkg::EV_ERROR) r.nesting_depth = 4'(lvl);

    // buffer ends with something still open
    if (fin && !fail_now && !latched_in && !(state == ST_TAG_FIRST && lvl == 0)) begin
      r.event_res      = btlv_pkg::EV_ERROR;
      code             = btlv_pkg::ERR_TRUNC;
      r.tag_value      = '0;
      r.value_length   = '0;
      r.object_class   = '0;
      r.is_constructed = 1'b0;
      r.tag_match      = 1'b0;
      r.levels_closed  = '0;
      r.nesting_depth  = 4'(lvl);
    end
    r.error_code = code;

    if (fin) clear_parser();
    return r;
  endfunction

  // one line per mismatch, all of them counted
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    $display("[%0t] result beat %0d %s: got 0x%0h, expected 0x%0h",
             $time, beat_no, what, got, want);
  endtask

  // field by field compare of one result beat
  task automatic check_beat(input btlv_pkg::out_beat_t got, input btlv_pkg::out_beat_t want);
    if (got.event_res !== want.event_res)
      report("event_res", 32'(got.event_res), 32'(want.event_res));
    if (got.tag_value !== want.tag_value)
      report("tag_value", got.tag_value, want.tag_value);
    if (got.value_length !== want.value_length)
      report("value_length", 32'(got.value_length), 32'(want.value_length));
    if (got.object_class !== want.object_class)
      report("object_class", 32'(got.object_class), 32'(want.object_class));
    if (got.is_constructed !== want.is_constructed)
      report("is_constructed", 32'(got.is_constructed), 32'(want.is_constructed));
    if (got.nesting_depth !== want.nesting_depth)
      report("nesting_depth", 32'(got.nesting_depth), 32'(want.nesting_depth));
    if (got.tag_match !== want.tag_match)
      report("tag_match", 32'(got.tag_match), 32'(want.tag_match));
    if (got.value_out !== want.value_out)
      report("value_out", 32'(got.value_out), 32'(want.value_out));
    if (got.levels_closed !== want.levels_closed)
      report("levels_closed", 32'(got.levels_closed), 32'(want.levels_closed));
    if (got.error_code !== want.error_code)
      report("error_code", 32'(got.error_code), 32'(want.error_code));
  endtask

  // watch the three channels at each edge: results first, then bytes, then config
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      search_tag = '0;
      fail_count = 0;
      beat_no    = 0;
      tlv_event_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        beat_no++;
        if (tlv_event_q.size() == 0)
          report("result with nothing expected", 32'(out_data.value_out), 32'd0);
        else
          check_beat(out_data, tlv_event_q.pop_front());
      end
      if (in_valid && in_ready)
        tlv_event_q.push_back(parse_byte(in_data.data_byte, in_data.last_byte));
      if (cfg_valid && cfg_ready) search_tag = cfg_data;
    end
    events_due = tlv_event_q.size();
  end

endmodule

// File: verif/ber_tlv_stream_parser_core_tb.sv
`timescale 1ns / 1ps
// testbench top for the ber-tlv stream parser: buffer stimulus, flow control and verdict
module ber_tlv_stream_parser_core_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int N_PHASES     = 8;

  typedef logic [7:0] byte_q_t [$];

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  btlv_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready;
  btlv_pkg::out_beat_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [31:0]         cfg_data;

  int          fail_count;
  int          events_due;
  int          items_sent;
  int          cycle_cnt;
  int          hold_left;
  int          rx_cycles;
  bit          calm;
  byte_q_t     dir_q;

  ber_tlv_stream_parser_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  btlv_parse_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .events_due (events_due)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stalls, a calm window and two long hold-offs
  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    rx_cycles = 0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == 1200 || rx_cycles == 3000) hold_left = 400;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // one input beat, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    calm = (items_sent >= 700 && items_sent < 1000);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: fin};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // a whole buffer, last byte marked
  task automatic send_all(ref byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // stop offering and let every owed result come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (events_due != 0);
    @(posedge clk);
  endtask

  task automatic write_search(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // tag: single byte, or a multi-byte form with some recurring values
  task automatic put_tag(ref byte_q_t q, input bit cons);
    logic [1:0] cls;
    logic [4:0] lo;
    int         extra;
    cls = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0) begin
      q.push_back({cls, cons, 5'h1F});
      case ($urandom_range(0, 2))
        0: q.push_back(8'h1A);
        1: begin
          q.push_back(8'h81);
          q.push_back(8'h01);
        end
        default: begin
          extra = $urandom_range(1, 3);
          repeat (extra - 1) q.push_back({1'b1, 7'($urandom)});
          q.push_back({1'b0, 7'($urandom)});
        end
      endcase
    end else begin
      lo = 5'($urandom_range(0, 30));
      if ($urandom_range(0, 3) == 0) lo = 5'h04;
      q.push_back({cls, cons, lo});
    end
  endtask

  // length in short form, long form of one or two bytes, or the zero-count form
  task automatic put_len(ref byte_q_t q, input int len);
    int sel;
    sel = $urandom_range(0, 3);
    if (len == 0 && sel == 3) begin
      q.push_back(8'h80);
    end else if (len < 128 && sel < 2) begin
      q.push_back(8'(len));
    end else if (len < 256 && sel != 3) begin
      q.push_back(8'h81);
      q.push_back(8'(len));
    end else begin
      q.push_back(8'h82);
      q.push_back(8'(len >> 8));
      q.push_back(8'(len));
    end
  endtask

  // primitive objects, mostly short with the odd long one
  task automatic put_prims(ref byte_q_t q, input int count);
    int len;
    repeat (count) begin
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 6);
      put_tag(q, 1'b0);
      put_len(q, len);
      repeat (len) q.push_back(8'($urandom));
    end
  endtask

  // nested object built inside out, with siblings at each level
  task automatic put_object(ref byte_q_t q, input int max_nest);
    byte_q_t body;
    byte_q_t outer;
    int      nest;
    nest = $urandom_range(0, max_nest);
    put_prims(body, $urandom_range(0, 2));
    repeat (nest) begin
      outer.delete();
      put_prims(outer, $urandom_range(0, 1));
      put_tag(outer, 1'b1);
      put_len(outer, body.size());
      foreach (body[i]) outer.push_back(body[i]);
      put_prims(outer, $urandom_range(0, 1));
      body = outer;
    end
    foreach (body[i]) q.push_back(body[i]);
  endtask

  // broken headers: long tag, bad length count, end past 16 bits, child past parent
  task automatic put_bad_header(ref byte_q_t q);
    case ($urandom_range(0, 4))
      0: begin
        q.push_back({2'($urandom), 1'($urandom), 5'h1F});
        repeat (4) q.push_back({1'b1, 7'($urandom)});
      end
      1: begin
        put_tag(q, 1'($urandom));
        q.push_back(8'(8'h83 + $urandom_range(0, 124)));
      end
      2: begin
        put_tag(q, 1'($urandom));
        q.push_back(8'h82);
        q.push_back(8'hFF);
        q.push_back(8'($urandom_range(252, 255)));
      end
      3: begin
        put_tag(q, 1'b1);
        q.push_back(8'h02);
        put_tag(q, 1'b0);
        q.push_back(8'h05);
      end
      default: begin
        put_tag(q, 1'b1);
        q.push_back(8'h01);
        q.push_back(8'h1F);
        q.push_back(8'h81);
      end
    endcase
  endtask

  // one random buffer: mostly well formed, some cut, corrupted, broken or noise
  task automatic send_random_buffer();
    byte_q_t bytes;
    int      kind;
    int      deep;
    int      cut;
    bit      noisy;
    noisy = 1'b0;
    deep  = ($urandom_range(0, 9) == 0) ? 9 : 3;
    kind  = $urandom_range(0, 99);
    repeat ($urandom_range(1, 3)) put_object(bytes, deep);
    if (kind >= 70 && kind < 78 && bytes.size() > 0) begin
      cut = $urandom_range(1, bytes.size());
      while (bytes.size() > cut) void'(bytes.pop_back());
    end else if (kind >= 78 && kind < 85 && bytes.size() > 0) begin
      bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom);
    end else if (kind >= 85 && kind < 94) begin
      put_bad_header(bytes);
      repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom));
    end else if (kind >= 94) begin
      bytes.delete();
      repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom));
      noisy = 1'b1;
    end
    if (bytes.size() == 0) bytes.push_back(8'($urandom));
    foreach (bytes[i])
      send_byte(bytes[i], (i == bytes.size() - 1) || (noisy && $urandom_range(0, 7) == 0));
  endtask

  // reset, directed buffers, then search-tag phases of random buffers
  initial begin
    int          ph;
    int          k;
    int          target;
    logic [31:0] search_vals [N_PHASES];
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    items_sent = 0;
    calm       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty object with tag zero, flagged against the reset search tag
    dir_q = '{8'h00, 8'h00};
    send_all(dir_q);
    // tag of five bytes, then a byte after the error
    dir_q = '{8'h1F, 8'h81, 8'h82, 8'h83, 8'h84, 8'h55};
    send_all(dir_q);
    // zero-count long length
    dir_q = '{8'h80, 8'h80};
    send_all(dir_q);
    // buffer ending inside a tag
    dir_q = '{8'hFF};
    send_all(dir_q);
    // eight nested constructed levels, a ninth overflows the stack
    dir_q.delete();
    for (k = 0; k < 9; k++) begin
      dir_q.push_back(8'h21);
      dir_q.push_back(8'(17 - 2 * k));
    end
    dir_q.push_back(8'h00);
    send_all(dir_q);

    search_vals = '{32'hFFFF_FFFF, 32'h0000_0004, 32'h0000_0000, 32'h0000_9F1A,
                    32'h00BF_8101, $urandom, 32'($urandom_range(0, 255)), 32'h0000_0021};
    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_drain();
      write_search(search_vals[ph]);
      target = items_sent + RANDOM_ITEMS / N_PHASES;
      while (items_sent < target) send_random_buffer();
    end

    wait_drain();
    repeat (3) @(posedge clk);
    if (fail_count == 0 && events_due == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
src/btlv_pkg.sv
src/btlv_stack_cell.sv
src/ber_tlv_stream_parser_core.sv
verif/btlv_parse_checker.sv
verif/ber_tlv_stream_parser_core_tb.sv
